// ===== design/sic_pkg.sv =====
// ----------------------------------------------------------------------------
// sic_pkg: shared types and constants for the segment intersection counter
// Coordinates, stored segment format, and the front/back queue word.
// ----------------------------------------------------------------------------
package sic_pkg;

    localparam int MAX_SEGMENTS = 256;
    localparam int COORD_BITS   = 12;
    localparam int IDX_BITS     = $clog2(MAX_SEGMENTS);
    localparam int CNT_BITS     = IDX_BITS + 1;
    localparam int SEG_BITS     = 4 * COORD_BITS;
    localparam int PAIR_BITS    = 15;
    localparam logic [PAIR_BITS-1:0] PAIR_MAX = {PAIR_BITS{1'b1}};
    localparam logic [11:0] NEAR_RESET = 12'd5;
    localparam int QDEPTH       = 2;

    // Signed widths for the cross product terms
    localparam int DIF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * DIF_BITS;

    typedef struct packed {
        logic [11:0] start_x;
        logic [11:0] start_y;
        logic [11:0] end_x;
        logic [11:0] end_y;
        logic        last_segment;
    } in_word_t;

    typedef struct packed {
        logic [PAIR_BITS-1:0] pair_count;
        logic                 overflow;
    } out_word_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
    } seg_t;

    // Queue word: classified by the front part
    typedef struct packed {
        seg_t seg;
        logic store;   // segment fits, test and store it
        logic last;    // emit and clear after this one
    } job_t;

endpackage

// ===== design/sic_ram.sv =====
// ----------------------------------------------------------------------------
// sic_ram: generic single-port-write, single-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module sic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/sic_front.sv =====
// ----------------------------------------------------------------------------
// sic_front: input classifier and job queue
// Tracks the set fill level, marks segments that fit, queues jobs.
// ----------------------------------------------------------------------------
module sic_front import sic_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  in_word_t in_word,
    output logic     busy,
    output logic     job_valid,
    output job_t     job,
    input  logic     job_pop
);

    logic [CNT_BITS-1:0] fill_reg, fill_next;
    job_t                q_reg [QDEPTH];
    logic [1:0]          qcnt_reg, qcnt_next;
    logic                push;
    job_t                new_job;

    assign busy      = (qcnt_reg == 2'(QDEPTH));
    assign push      = start && !busy;
    assign job_valid = (qcnt_reg != 2'd0);
    assign job       = q_reg[0];

    // Classify: store only while the set has room
    always_comb
    begin
        new_job.seg.x0 = in_word.start_x[COORD_BITS-1:0];
        new_job.seg.y0 = in_word.start_y[COORD_BITS-1:0];
        new_job.seg.x1 = in_word.end_x[COORD_BITS-1:0];
        new_job.seg.y1 = in_word.end_y[COORD_BITS-1:0];
        new_job.store  = (fill_reg < CNT_BITS'(MAX_SEGMENTS));
        new_job.last   = in_word.last_segment;
        fill_next = fill_reg;
        if (push)
        begin
            if (in_word.last_segment)
                fill_next = '0;
            else if (new_job.store)
                fill_next = fill_reg + 1'b1;
        end
        qcnt_next = qcnt_reg + {1'b0, push} - {1'b0, job_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            qcnt_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            qcnt_reg <= qcnt_next;
        end
    end

    // Two-entry shift queue payload
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            // push with pop only happens with one word queued
            if (push)
                q_reg[0] <= new_job;
            else
                q_reg[0] <= q_reg[1];
        end
        else if (push)
        begin
            q_reg[qcnt_reg[0]] <= new_job;
        end
    end

endmodule

// ===== design/sic_back.sv =====
// ----------------------------------------------------------------------------
// sic_back: pair tester
// Sweeps the stored segments one per cycle against the current job.
// ----------------------------------------------------------------------------
module sic_back import sic_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic [11:0] near_limit,
    input  logic      job_valid,
    input  job_t      job,
    output logic      job_pop,
    output logic      result_valid,
    output out_word_t result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [CNT_BITS-1:0]  idx_reg, idx_next;
    logic                 rvalid_reg;   // RAM data valid this cycle
    logic [PAIR_BITS-1:0] pairs_reg, pairs_next;
    logic                 drop_reg, drop_next;
    job_t                 cur_reg;
    logic                 rv_reg;
    out_word_t            res_reg;
    logic                 we;
    logic [SEG_BITS-1:0]  rdata;
    seg_t                 p;
    seg_t                 q;
    logic                 hit;
    logic                 cross_valid_reg;
    logic                 hit_reg;

    assign q = cur_reg.seg;
    assign p = seg_t'(rdata);

    sic_ram #(.WIDTH(SEG_BITS), .DEPTH(MAX_SEGMENTS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[IDX_BITS-1:0]),
        .wdata (SEG_BITS'(cur_reg.seg)),
        .raddr (idx_reg[IDX_BITS-1:0]),
        .rdata (rdata)
    );

    function automatic logic nearpt(input logic [COORD_BITS-1:0] ax, ay, bx, by,
                                    input logic [11:0] lim);
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        return (16'(dx) < 16'(lim)) && (16'(dy) < 16'(lim));
    endfunction

    function automatic logic signed [1:0] side(input seg_t s,
                                               input logic [COORD_BITS-1:0] px, py);
        logic signed [DIF_BITS-1:0]  ax, ay, bx, by;
        logic signed [PROD_BITS:0]   v;
        ax = $signed({1'b0, s.x1}) - $signed({1'b0, s.x0});
        ay = $signed({1'b0, s.y1}) - $signed({1'b0, s.y0});
        bx = $signed({1'b0, px}) - $signed({1'b0, s.x0});
        by = $signed({1'b0, py}) - $signed({1'b0, s.y0});
        v = (PROD_BITS+1)'(ax * by) - (PROD_BITS+1)'(ay * bx);
        return (v > 0) ? 2'sd1 : ((v < 0) ? -2'sd1 : 2'sd0);
    endfunction

    // Pair test on the stored segment p and the new segment q
    always_comb
    begin
        logic signed [1:0] a0, a1, b0, b1;
        a0 = side(p, q.x0, q.y0);
        a1 = side(p, q.x1, q.y1);
        b0 = side(q, p.x0, p.y0);
        b1 = side(q, p.x1, p.y1);
        hit = !nearpt(p.x0, p.y0, q.x0, q.y0, near_limit)
           && !nearpt(p.x1, p.y1, q.x1, q.y1, near_limit)
           && !((a0 != 0) && (a0 == a1))
           && !((b0 != 0) && (b0 == b1));
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pairs_next = pairs_reg;
        drop_next  = drop_reg;
        job_pop    = 1'b0;
        we         = 1'b0;
        if (cross_valid_reg && hit_reg && pairs_reg != PAIR_MAX)
            pairs_next = pairs_reg + 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!cur_reg.store)
                begin
                    drop_next  = 1'b1;
                    state_next = S_DONE;
                end
                else if (idx_reg < count_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    we         = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // wait for the last pipelined test to land
                if (!rvalid_reg && !cross_valid_reg)
                begin
                    state_next = S_IDLE;
                    if (cur_reg.last)
                    begin
                        count_next = '0;
                        pairs_next = '0;
                        drop_next  = 1'b0;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            idx_reg         <= '0;
            pairs_reg       <= '0;
            drop_reg        <= 1'b0;
            rvalid_reg      <= 1'b0;
            cross_valid_reg <= 1'b0;
            rv_reg          <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            idx_reg         <= idx_next;
            pairs_reg       <= pairs_next;
            drop_reg        <= drop_next;
            rvalid_reg      <= (state_reg == S_SCAN) && cur_reg.store && (idx_reg < count_reg);
            cross_valid_reg <= rvalid_reg;
            rv_reg          <= (state_reg == S_DONE) && !rvalid_reg && !cross_valid_reg
                               && cur_reg.last;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (job_pop)
            cur_reg <= job;
        hit_reg <= hit;
        if ((state_reg == S_DONE) && !rvalid_reg && !cross_valid_reg)
        begin
            res_reg.pair_count <= pairs_reg;
            res_reg.overflow   <= drop_reg;
        end
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

endmodule

// ===== design/segment_intersection_count_core.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_count_core: pairwise segment intersection counter
// Stores segments and counts intersecting pairs per set.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (segment endpoints plus a last mark) are taken when start is
//   high and busy is low. A two-word queue separates the classifier from the
//   tester, so a word can be taken while the previous one is still at work.
//   The tester reads one stored segment per cycle from the segment RAM;
//   only written entries are read, so the RAM needs no clearing. It works
//   on one word at a time and picks a queued word up in the cycle after
//   it is taken when idle.
//   On a word marked last, one result word (pair_count, overflow) appears on
//   result for one cycle with done high, in the cycle right after the tester
//   finishes that word, and the set is cleared. The receiver cannot stall;
//   results are never held.
//   near_limit is written through cfg_we/cfg_data; the user must write it
//   only while idle, as the block does not enforce this. Reset clears the
//   set, the counters and the queue; near_limit returns to 5.
// ----------------------------------------------------------------------------
module segment_intersection_count_core import sic_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  in_word_t    item,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [11:0] cfg_data,
    output logic        done,
    output out_word_t   result
);

    logic [11:0] near_limit_reg;
    logic        job_valid;
    job_t        job;
    logic        job_pop;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            near_limit_reg <= NEAR_RESET;
        else if (cfg_we)
            near_limit_reg <= cfg_data;
    end

    sic_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .in_word   (item),
        .busy      (busy),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    sic_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .near_limit   (near_limit_reg),
        .job_valid    (job_valid),
        .job          (job),
        .job_pop      (job_pop),
        .result_valid (done),
        .result       (result)
    );

endmodule

// ===== dv/tb_segment_intersection_count_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_intersection_count_core: self-checking bench for the counter
// Sends segment words under random start gaps, predicts the pair count and
// overflow of each set, and compares every done word against the prediction.
// ----------------------------------------------------------------------------
module tb_segment_intersection_count_core;
    import sic_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    in_word_t    item = '0;
    logic        busy;
    logic        cfg_we = 1'b0;
    logic [11:0] cfg_data = '0;
    logic        done;
    out_word_t   result;

    // Predictor state
    seg_t        set_segs[MAX_SEGMENTS];
    int          set_size;
    int          set_pairs;
    bit          set_dropped;
    int          near_lim;
    out_word_t   pending_counts[$];

    int          n_errors = 0;
    int          gap_pct = 0;

    segment_intersection_count_core u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .item(item), .busy(busy),
        .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .result(result)
    );

    always #6 clk = ~clk;

    // Side of point p relative to the line of s: -1, 0 or 1
    function automatic int side_of(seg_t s, logic [COORD_BITS-1:0] px,
                                   logic [COORD_BITS-1:0] py);
        longint v;
        v = longint'(int'(s.x1) - int'(s.x0)) * (int'(py) - int'(s.y0))
          - longint'(int'(s.y1) - int'(s.y0)) * (int'(px) - int'(s.x0));
        return (v > 0) - (v < 0);
    endfunction

    function automatic bit pts_near(logic [COORD_BITS-1:0] ax, ay, bx, by);
        int dx, dy;
        dx = ax > bx ? int'(ax) - int'(bx) : int'(bx) - int'(ax);
        dy = ay > by ? int'(ay) - int'(by) : int'(by) - int'(ay);
        return dx < near_lim && dy < near_lim;
    endfunction

    function automatic bit segs_cross(seg_t p, seg_t q);
        if (pts_near(p.x0, p.y0, q.x0, q.y0)) return 0;
        if (pts_near(p.x1, p.y1, q.x1, q.y1)) return 0;
        if (side_of(q, p.x0, p.y0) * side_of(q, p.x1, p.y1) > 0) return 0;
        if (side_of(p, q.x0, q.y0) * side_of(p, q.x1, q.y1) > 0) return 0;
        return 1;
    endfunction

    // Update the set and queue the count word on a last mark
    task automatic predict_word(in_word_t w);
        seg_t s;
        out_word_t o;
        s = '{w.start_x, w.start_y, w.end_x, w.end_y};
        if (set_size < MAX_SEGMENTS) begin
            for (int i = 0; i < set_size; i++)
                if (segs_cross(set_segs[i], s) && set_pairs < 32767)
                    set_pairs++;
            set_segs[set_size] = s;
            set_size++;
        end
        else begin
            set_dropped = 1;
        end
        if (w.last_segment) begin
            o.pair_count = set_pairs[PAIR_BITS-1:0];
            o.overflow = set_dropped;
            pending_counts = {pending_counts, o};
            set_size = 0;
            set_pairs = 0;
            set_dropped = 0;
        end
    endtask

    // Send one word, with a random idle gap before it; returns at the taking edge
    task automatic send_word(in_word_t w);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        item <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_word(w);
    endtask

    function automatic in_word_t rand_word(bit last);
        in_word_t w;
        w.start_x = 12'($urandom);
        w.start_y = 12'($urandom);
        w.end_x = 12'($urandom);
        w.end_y = 12'($urandom);
        w.last_segment = last;
        return w;
    endfunction

    function automatic in_word_t mk(int x0, int y0, int x1, int y1, bit last);
        return '{12'(x0), 12'(y0), 12'(x1), 12'(y1), last};
    endfunction

    // Wait until all counts are in, plus the tester's worst latency
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_counts.size() != 0)
            @(negedge clk);
        repeat (600) @(negedge clk);
    endtask

    task automatic write_near(int v);
        cfg_we <= 1'b1;
        cfg_data <= 12'(v);
        @(negedge clk);
        cfg_we <= 1'b0;
        near_lim = v;
    endtask

    // Check each done word against the oldest prediction
    always @(posedge clk) begin
        if (done) begin
            if (pending_counts.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result word %h", result);
            end
            else begin
                out_word_t e;
                e = pending_counts.pop_front();
                if (e.pair_count !== result.pair_count || e.overflow !== result.overflow) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: exp count %0d ovf %0b, got count %0d ovf %0b",
                                 e.pair_count, e.overflow, result.pair_count,
                                 result.overflow);
                end
            end
        end
    end

    // Crossings, touching, zero length, near exclusion, extremes
    task automatic test_directed();
        send_word(mk(0, 0, 4095, 4095, 0));
        send_word(mk(0, 4095, 4095, 0, 0));
        send_word(mk(2048, 0, 2048, 4095, 0));
        send_word(mk(100, 100, 100, 100, 0));
        send_word(mk(2048, 2048, 2048, 2048, 0));
        send_word(mk(2, 3, 4000, 10, 0));
        send_word(mk(0, 0, 4095, 0, 0));
        send_word(mk(4095, 4095, 0, 0, 1));
        // no crossings at all
        send_word(mk(0, 0, 10, 0, 0));
        send_word(mk(0, 100, 10, 100, 1));
        // single segment set
        send_word(mk(4095, 0, 0, 4095, 1));
        // T junction: endpoint on the other line
        send_word(mk(0, 500, 1000, 500, 0));
        send_word(mk(500, 500, 500, 1000, 1));
    endtask

    // Random sets of small size, each closed by a last mark
    task automatic test_random(int n_items);
        int left;
        left = n_items;
        while (left > 0) begin
            int len;
            len = $urandom_range(1, 12);
            for (int i = 0; i < len && left > 0; i++, left--) begin
                in_word_t w;
                w = rand_word(i == len - 1 || left == 1);
                if ($urandom_range(9) == 0) begin
                    // short segment: end point near its own start point
                    w.end_x = w.start_x ^ 12'($urandom_range(7));
                    w.end_y = w.start_y ^ 12'($urandom_range(7));
                end
                send_word(w);
            end
        end
    endtask

    // Overflow the store: 256 fill plus dropped words, then a dropped last
    task automatic test_overflow();
        for (int i = 0; i < MAX_SEGMENTS + 3; i++)
            send_word(rand_word(0));
        send_word(rand_word(1));
    endtask

    initial begin
        set_size = 0;
        set_pairs = 0;
        set_dropped = 0;
        near_lim = 5;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        gap_pct = 25;
        test_directed();
        drain();
        write_near(0);
        test_directed();
        test_random(80);
        drain();
        write_near(4095);
        gap_pct = 88;
        test_random(50);
        drain();
        write_near(200);
        test_random(80);
        drain();
        gap_pct = 0;
        write_near(5);
        test_overflow();
        test_random(50);
        drain();

        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #30ms;
        $display("FAILURE");
        $finish;
    end
endmodule

// ===== files.f =====
design/sic_pkg.sv
design/sic_ram.sv
design/sic_front.sv
design/sic_back.sv
design/segment_intersection_count_core.sv
dv/tb_segment_intersection_count_core.sv
